/* design/kwtq_pkg.sv */
// ----------------------------------------------------------------------------
// kwtq_pkg
// Types and constants shared by the keyword trigger qualifier modules.
// ----------------------------------------------------------------------------
package kwtq_pkg;

   localparam int TimeWidth    = 48;
   localparam int ScoreWidth   = 16;
   localparam int CountWidth   = 32;
   localparam int NumCounters  = 8;

   localparam logic [ScoreWidth-1:0] Q15One = 16'd32768;

   // Reset values of the configuration registers.
   localparam logic [15:0] ThresholdReset = 16'd26214;
   localparam logic [15:0] HitsReset      = 16'd3;
   localparam logic [31:0] CooldownReset  = 32'd2000;

   // Configuration register indexes.
   localparam logic [1:0] CSR_THRESHOLD = 2'd0;
   localparam logic [1:0] CSR_HITS      = 2'd1;
   localparam logic [1:0] CSR_COOLDOWN  = 2'd2;

   // Item commands.
   localparam logic [1:0] CMD_FRAME  = 2'd0;
   localparam logic [1:0] CMD_TRESET = 2'd1;
   localparam logic [1:0] CMD_CLEAR  = 2'd2;

   // Statistics counter positions, in result field order.
   localparam int CNT_FRAMES = 0;
   localparam int CNT_ABOVE  = 1;
   localparam int CNT_TRIG   = 2;
   localparam int CNT_COOL   = 3;
   localparam int CNT_LATCH  = 4;
   localparam int CNT_RANGE  = 5;
   localparam int CNT_CLOCK  = 6;
   localparam int CNT_TRESET = 7;

   typedef enum logic [2:0] {
      DEC_IDLE  = 3'd0,
      DEC_CAND  = 3'd1,
      DEC_TRIG  = 3'd2,
      DEC_SUPP  = 3'd3,
      DEC_RANGE = 3'd4,
      DEC_CLOCK = 3'd5,
      DEC_CMD   = 3'd6
   } decision_type;

   typedef struct packed {
      logic [1:0]            command;
      logic [ScoreWidth-1:0] score;
      logic [TimeWidth-1:0]  timestamp;
   } req_type;

   typedef struct packed {
      decision_type          decision;
      logic                  in_cooldown;
      logic [CountWidth-1:0] valid_frame_count;
      logic [CountWidth-1:0] above_threshold_count;
      logic [CountWidth-1:0] trigger_count;
      logic [CountWidth-1:0] cooldown_suppress_count;
      logic [CountWidth-1:0] latched_suppress_count;
      logic [CountWidth-1:0] range_error_count;
      logic [CountWidth-1:0] clock_error_count;
      logic [CountWidth-1:0] temporal_reset_count;
   } rsp_type;

   typedef struct packed {
      logic [15:0] score_threshold;
      logic [15:0] hits_to_trigger;
      logic [31:0] cooldown_period;
   } cfg_type;

   typedef struct packed {
      logic [TimeWidth-1:0] last_frame_time;
      logic [TimeWidth-1:0] last_trigger_time;
      logic [15:0]          hit_run;
      logic                 time_valid;
      logic                 trigger_valid;
      logic                 armed;
   } temporal_type;

   typedef struct packed {
      logic                   clear;
      logic [NumCounters-1:0] bump;
   } event_type;

   typedef logic [NumCounters-1:0][CountWidth-1:0] counters_type;

endpackage

/* design/kwtq_eval.sv */
// ----------------------------------------------------------------------------
// kwtq_eval
// Per-item decision logic: next temporal state, counter events and result.
// ----------------------------------------------------------------------------
module kwtq_eval
   import kwtq_pkg::*;
(
   input  cfg_type      cfg,
   input  temporal_type st,
   input  req_type      item,
   output temporal_type st_next,
   output event_type    ev,
   output decision_type decision,
   output logic         in_cooldown
);

   logic                 range_err;
   logic                 backward;
   logic                 hit;
   logic [TimeWidth:0]   trig_diff;
   logic                 cool_core;
   logic                 period_on;
   logic [15:0]          run_inc;

   assign range_err = item.score > Q15One;
   assign backward  = st.time_valid && (item.timestamp < st.last_frame_time);
   assign hit       = item.score >= cfg.score_threshold;
   assign period_on = cfg.cooldown_period != '0;

   // The top bit of the difference is the borrow: the timestamp is before
   // the last trigger.
   assign trig_diff = {1'b0, item.timestamp} - {1'b0, st.last_trigger_time};
   assign cool_core = st.trigger_valid && period_on && !trig_diff[TimeWidth]
                      && (trig_diff[TimeWidth-1:32] == '0)
                      && (trig_diff[31:0] < cfg.cooldown_period);

   assign run_inc = (st.hit_run == '1) ? st.hit_run : st.hit_run + 16'd1;

   always_comb begin
      st_next     = st;
      ev          = '0;
      decision    = DEC_CMD;
      in_cooldown = cool_core && !backward;
      case (item.command)
         CMD_FRAME: begin
            if (range_err) begin
               ev.bump[CNT_RANGE] = 1'b1;
               st_next.hit_run    = '0;
               decision           = DEC_RANGE;
            end else if (backward) begin
               ev.bump[CNT_CLOCK]      = 1'b1;
               ev.bump[CNT_TRESET]     = 1'b1;
               st_next.last_frame_time = item.timestamp;
               st_next.last_trigger_time = '0;
               st_next.hit_run         = '0;
               st_next.time_valid      = 1'b1;
               st_next.trigger_valid   = 1'b0;
               st_next.armed           = 1'b1;
               decision                = DEC_CLOCK;
               in_cooldown             = 1'b0;
            end else begin
               st_next.last_frame_time = item.timestamp;
               st_next.time_valid      = 1'b1;
               ev.bump[CNT_FRAMES]     = 1'b1;
               in_cooldown             = cool_core;
               if (!hit) begin
                  st_next.hit_run = '0;
                  st_next.armed   = 1'b1;
                  decision        = DEC_IDLE;
               end else begin
                  ev.bump[CNT_ABOVE] = 1'b1;
                  if (cool_core) begin
                     st_next.hit_run   = '0;
                     ev.bump[CNT_COOL] = 1'b1;
                     decision          = DEC_SUPP;
                  end else if (!st.armed) begin
                     st_next.hit_run    = '0;
                     ev.bump[CNT_LATCH] = 1'b1;
                     decision           = DEC_SUPP;
                  end else if (run_inc < cfg.hits_to_trigger) begin
                     st_next.hit_run = run_inc;
                     decision        = DEC_CAND;
                  end else begin
                     st_next.hit_run           = '0;
                     st_next.armed             = 1'b0;
                     st_next.last_trigger_time = item.timestamp;
                     st_next.trigger_valid     = 1'b1;
                     ev.bump[CNT_TRIG]         = 1'b1;
                     decision                  = DEC_TRIG;
                     // A fresh trigger is cooling exactly when the period is set.
                     in_cooldown               = period_on;
                  end
               end
            end
         end
         CMD_TRESET: begin
            st_next.last_frame_time   = '0;
            st_next.last_trigger_time = '0;
            st_next.hit_run           = '0;
            st_next.time_valid        = 1'b0;
            st_next.trigger_valid     = 1'b0;
            st_next.armed             = 1'b1;
            ev.bump[CNT_TRESET]       = 1'b1;
            in_cooldown               = 1'b0;
         end
         CMD_CLEAR: begin
            ev.clear = 1'b1;
         end
         default: begin
         end
      endcase
   end

endmodule

/* design/kwtq_stats.sv */
// ----------------------------------------------------------------------------
// kwtq_stats
// Bank of saturating statistics counters; the registers drive the result.
// ----------------------------------------------------------------------------
module kwtq_stats
   import kwtq_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         enable,
   input  event_type    ev,
   output counters_type counts
);

   counters_type cnt_ff;
   counters_type cnt_in;

   always_comb begin
      cnt_in = cnt_ff;
      if (enable) begin
         if (ev.clear) begin
            cnt_in = '0;
         end else begin
            for (int i = 0; i < NumCounters; i++) begin
               if (ev.bump[i] && (cnt_ff[i] != '1)) begin
                  cnt_in[i] = cnt_ff[i] + 32'd1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   assign counts = cnt_ff;

endmodule

/* design/keyword_trigger_qualifier_core.sv */
// ----------------------------------------------------------------------------
// keyword_trigger_qualifier_core
// Qualifies timestamped keyword-detector scores into trigger decisions.
// ----------------------------------------------------------------------------
// An item passes the input register, then the result register. Throughput:
// one item per cycle unless the result stalls; the input register, one pass
// through the decision logic and the result register bound the rate.
// The counters double as the result register for the statistics fields.
// Reset (synchronous) restores the register defaults, arms the qualifier,
// clears the counters and empties both stages.
module keyword_trigger_qualifier_core
   import kwtq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);

   req_type      item_ff;
   logic         item_valid_ff;
   cfg_type      cfg_ff;
   temporal_type st_ff;
   temporal_type st_in;
   event_type    ev;
   decision_type decision;
   logic         in_cooldown;
   decision_type decision_ff;
   logic         cool_ff;
   logic         rsp_valid_ff;
   logic         advance;
   counters_type counts;

   // The item in the input register moves on once the result slot is free.
   assign advance   = item_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !item_valid_ff || advance;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (req_ready) begin
         item_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.score_threshold <= ThresholdReset;
         cfg_ff.hits_to_trigger <= HitsReset;
         cfg_ff.cooldown_period <= CooldownReset;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_THRESHOLD: cfg_ff.score_threshold <= csr_data[15:0];
            CSR_HITS:      cfg_ff.hits_to_trigger <= csr_data[15:0];
            CSR_COOLDOWN:  cfg_ff.cooldown_period <= csr_data;
            default: begin
            end
         endcase
      end
   end

   kwtq_eval u_eval (
      .cfg         (cfg_ff),
      .st          (st_ff),
      .item        (item_ff),
      .st_next     (st_in),
      .ev          (ev),
      .decision    (decision),
      .in_cooldown (in_cooldown)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff.last_frame_time   <= '0;
         st_ff.last_trigger_time <= '0;
         st_ff.hit_run           <= '0;
         st_ff.time_valid        <= 1'b0;
         st_ff.trigger_valid     <= 1'b0;
         st_ff.armed             <= 1'b1;
      end else if (advance) begin
         st_ff <= st_in;
      end
   end

   kwtq_stats u_stats (
      .clock  (clock),
      .reset  (reset),
      .enable (advance),
      .ev     (ev),
      .counts (counts)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         decision_ff <= decision;
         cool_ff     <= in_cooldown;
      end
   end

   assign rsp_valid                        = rsp_valid_ff;
   assign rsp_data.decision                = decision_ff;
   assign rsp_data.in_cooldown             = cool_ff;
   assign rsp_data.valid_frame_count       = counts[CNT_FRAMES];
   assign rsp_data.above_threshold_count   = counts[CNT_ABOVE];
   assign rsp_data.trigger_count           = counts[CNT_TRIG];
   assign rsp_data.cooldown_suppress_count = counts[CNT_COOL];
   assign rsp_data.latched_suppress_count  = counts[CNT_LATCH];
   assign rsp_data.range_error_count       = counts[CNT_RANGE];
   assign rsp_data.clock_error_count       = counts[CNT_CLOCK];
   assign rsp_data.temporal_reset_count    = counts[CNT_TRESET];

endmodule

/* design/kwtq_checker.sv */
// ----------------------------------------------------------------------------
// kwtq_checker
// Port-level checks for the keyword trigger qualifier, bound to the top level.
// ----------------------------------------------------------------------------
module kwtq_checker
   import kwtq_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // A stalled item keeps its place and its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result item changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // Every trigger is also an above-threshold frame, which is also a frame.
   a_count_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.trigger_count <= rsp_data.above_threshold_count)
                 && (rsp_data.above_threshold_count <= rsp_data.valid_frame_count))
      else $error("statistics counters out of order");

   // A clock error drops the trigger history, so no cooldown can follow.
   a_clock_no_cool: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.decision == DEC_CLOCK) |-> !rsp_data.in_cooldown)
      else $error("cooldown reported after a clock error");

endmodule

bind keyword_trigger_qualifier_core kwtq_checker u_kwtq_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

/* test/keyword_trigger_qualifier_core_tb.sv */
// ----------------------------------------------------------------------------
// keyword_trigger_qualifier_core_tb
// Self-checking bench for the keyword trigger qualifier. A queue of frames
// and commands feeds a valid/ready driver, a score qualifier written here
// predicts every result item, and a monitor compares each result field by
// field. Phases with different threshold, hit count and cooldown settings
// are separated by idle points where the registers are rewritten.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module keyword_trigger_qualifier_core_tb;
   import kwtq_pkg::*;

   localparam logic [1:0] CMD_UNUSED   = 2'd3;
   localparam logic [1:0] CSR_UNUSED   = 2'd3;
   localparam int         RandomPhases = 8;
   localparam int         PhaseItems   = 55;
   localparam int         LongHold     = 300;
   localparam int         CycleLimit   = 100000;

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data  = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [31:0] csr_data  = '0;

   keyword_trigger_qualifier_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #1 clock = ~clock;

   // Register copies and temporal state of the score qualifier.
   logic [15:0]          threshold_cfg   = ThresholdReset;
   logic [15:0]          hits_cfg        = HitsReset;
   logic [31:0]          cooldown_cfg    = CooldownReset;
   logic [TimeWidth-1:0] prev_frame_ms   = '0;
   logic [TimeWidth-1:0] trigger_ms      = '0;
   logic [15:0]          run_length      = '0;
   logic                 have_frame_time = 1'b0;
   logic                 have_trigger    = 1'b0;
   logic                 armed_now       = 1'b1;
   logic [CountWidth-1:0] stat_count [NumCounters] = '{default: '0};

   req_type              pending_items[$];
   rsp_type              expected_results[$];
   logic [TimeWidth-1:0] stim_ms        = '0;
   int                   mismatch_count = 0;
   int                   cycle_count    = 0;
   int                   send_wait      = 0;
   int                   recv_wait      = 0;
   int                   hold_left      = 0;
   int                   holds_asked    = 0;
   int                   holds_served   = 0;
   bit                   send_idling    = 1'b1;
   bit                   recv_idling    = 1'b1;

   function automatic void bump_stat(int which);
      if (stat_count[which] != '1) stat_count[which] = stat_count[which] + 1'b1;
   endfunction

   function automatic void clear_temporal();
      prev_frame_ms   = '0;
      trigger_ms      = '0;
      run_length      = '0;
      have_frame_time = 1'b0;
      have_trigger    = 1'b0;
      armed_now       = 1'b1;
      bump_stat(CNT_TRESET);
   endfunction

   function automatic logic cooldown_active(logic [TimeWidth-1:0] now);
      if (!have_trigger || cooldown_cfg == '0) return 1'b0;
      if (have_frame_time && now < prev_frame_ms) return 1'b0;
      if (now < trigger_ms) return 1'b0;
      return (now - trigger_ms) < TimeWidth'(cooldown_cfg);
   endfunction

   function automatic rsp_type qualify_score(req_type item);
      rsp_type      result;
      decision_type verdict;
      verdict = DEC_CMD;
      case (item.command)
         CMD_FRAME: begin
            if (item.score > Q15One) begin
               bump_stat(CNT_RANGE);
               run_length = '0;
               verdict = DEC_RANGE;
            end else if (have_frame_time && item.timestamp < prev_frame_ms) begin
               bump_stat(CNT_CLOCK);
               clear_temporal();
               prev_frame_ms = item.timestamp;
               have_frame_time = 1'b1;
               verdict = DEC_CLOCK;
            end else begin
               prev_frame_ms = item.timestamp;
               have_frame_time = 1'b1;
               bump_stat(CNT_FRAMES);
               if (item.score < threshold_cfg) begin
                  run_length = '0;
                  armed_now = 1'b1;
                  verdict = DEC_IDLE;
               end else begin
                  bump_stat(CNT_ABOVE);
                  if (cooldown_active(item.timestamp)) begin
                     run_length = '0;
                     bump_stat(CNT_COOL);
                     verdict = DEC_SUPP;
                  end else if (!armed_now) begin
                     run_length = '0;
                     bump_stat(CNT_LATCH);
                     verdict = DEC_SUPP;
                  end else begin
                     if (run_length != 16'hFFFF) run_length = run_length + 1'b1;
                     if (run_length < hits_cfg) begin
                        verdict = DEC_CAND;
                     end else begin
                        run_length = '0;
                        armed_now = 1'b0;
                        trigger_ms = item.timestamp;
                        have_trigger = 1'b1;
                        bump_stat(CNT_TRIG);
                        verdict = DEC_TRIG;
                     end
                  end
               end
            end
         end
         CMD_TRESET: clear_temporal();
         CMD_CLEAR: foreach (stat_count[i]) stat_count[i] = '0;
         default: ;  // the spare command code leaves everything as it is
      endcase
      result.decision                = verdict;
      result.in_cooldown             = cooldown_active(item.timestamp);
      result.valid_frame_count       = stat_count[CNT_FRAMES];
      result.above_threshold_count   = stat_count[CNT_ABOVE];
      result.trigger_count           = stat_count[CNT_TRIG];
      result.cooldown_suppress_count = stat_count[CNT_COOL];
      result.latched_suppress_count  = stat_count[CNT_LATCH];
      result.range_error_count       = stat_count[CNT_RANGE];
      result.clock_error_count       = stat_count[CNT_CLOCK];
      result.temporal_reset_count    = stat_count[CNT_TRESET];
      return result;
   endfunction

   function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         mismatch_count++;
      end
   endfunction

   // Sender: predicts each item as it is accepted, then offers the next one
   // after a drawn number of idle cycles.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_wait <= 0;
      end else begin
         if (req_valid && req_ready) expected_results.push_back(qualify_score(req_data));
         if (!req_valid || req_ready) begin
            if (send_wait != 0) begin
               send_wait <= send_wait - 1;
               req_valid <= 1'b0;
            end else if (pending_items.size() != 0) begin
               req_data  <= pending_items.pop_front();
               req_valid <= 1'b1;
               send_wait <= send_idling ? $urandom_range(0, 7) : 0;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: a drawn stall after every result item, and a long hold-off
   // whenever the stimulus asks for one.
   always @(posedge clock) begin : receiver
      int pause;
      if (reset) begin
         rsp_ready <= 1'b0;
         recv_wait <= 0;
         hold_left <= 0;
      end else if (holds_served != holds_asked) begin
         holds_served <= holds_served + 1;
         hold_left    <= LongHold;
         rsp_ready    <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (rsp_valid && rsp_ready) begin
         pause = recv_idling ? $urandom_range(0, 7) : 0;
         rsp_ready <= (pause == 0);
         recv_wait <= (pause == 0) ? 0 : pause - 1;
      end else if (recv_wait != 0) begin
         recv_wait <= recv_wait - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin : result_monitor
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            $error("result item arrived with no item outstanding");
            mismatch_count++;
         end else begin
            want = expected_results.pop_front();
            check_field("decision", 32'(want.decision), 32'(rsp_data.decision));
            check_field("in_cooldown", 32'(want.in_cooldown), 32'(rsp_data.in_cooldown));
            check_field("valid_frame_count", want.valid_frame_count,
                        rsp_data.valid_frame_count);
            check_field("above_threshold_count", want.above_threshold_count,
                        rsp_data.above_threshold_count);
            check_field("trigger_count", want.trigger_count, rsp_data.trigger_count);
            check_field("cooldown_suppress_count", want.cooldown_suppress_count,
                        rsp_data.cooldown_suppress_count);
            check_field("latched_suppress_count", want.latched_suppress_count,
                        rsp_data.latched_suppress_count);
            check_field("range_error_count", want.range_error_count,
                        rsp_data.range_error_count);
            check_field("clock_error_count", want.clock_error_count,
                        rsp_data.clock_error_count);
            check_field("temporal_reset_count", want.temporal_reset_count,
                        rsp_data.temporal_reset_count);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("keyword_trigger_qualifier_core regression: fail");
         $finish;
      end
   end

   task automatic add_item(input logic [1:0] cmd, input logic [15:0] score,
                           input logic [TimeWidth-1:0] stamp);
      req_type item;
      item.command   = cmd;
      item.score     = score;
      item.timestamp = stamp;
      pending_items.push_back(item);
   endtask

   // Scores are spread over below-threshold, hit and out-of-range values
   // according to the threshold currently programmed.
   function automatic logic [15:0] pick_score();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 5) return 16'($urandom_range(Q15One + 1, 16'hFFFF));
      if (roll < 30 && threshold_cfg != '0) return 16'($urandom_range(0, threshold_cfg - 1));
      if (threshold_cfg <= Q15One) return 16'($urandom_range(threshold_cfg, Q15One));
      return 16'($urandom_range(0, Q15One));
   endfunction

   // Mostly frames on a rising timeline, with commands, backward steps and
   // jumps to arbitrary 48-bit times mixed in.
   task automatic add_random_items(input int count);
      logic [1:0] spare_cmds [3] = '{CMD_TRESET, CMD_CLEAR, CMD_UNUSED};
      int         roll;
      int         back;
      for (int n = 0; n < count; n++) begin
         roll = $urandom_range(0, 99);
         if (roll < 6) begin
            add_item(spare_cmds[$urandom_range(0, 2)], 16'($urandom),
                     {16'($urandom), 32'($urandom)});
         end else if (roll < 10) begin
            back = $urandom_range(1, 500);
            stim_ms = (stim_ms > back) ? stim_ms - back : '0;
            add_item(CMD_FRAME, pick_score(), stim_ms);
         end else begin
            if (roll < 12) stim_ms = {16'($urandom), 32'($urandom)};
            else if (roll < 20) stim_ms = stim_ms;
            else if (roll < 80) stim_ms = stim_ms + $urandom_range(1, 60);
            else if (roll < 96) stim_ms = stim_ms + $urandom_range(61, 2500);
            else stim_ms = stim_ms + $urandom_range(2501, 100000);
            add_item(CMD_FRAME, pick_score(), stim_ms);
         end
      end
   endtask

   task automatic write_register(input logic [1:0] reg_index, input logic [31:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= reg_index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (reg_index)
         CSR_THRESHOLD: threshold_cfg = value[15:0];
         CSR_HITS:      hits_cfg = value[15:0];
         CSR_COOLDOWN:  cooldown_cfg = value;
         default: ;  // writes outside the register map are dropped
      endcase
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (pending_items.size() != 0 || req_valid || expected_results.size() != 0);
   endtask

   initial begin : stimulus
      int          roll;
      logic [15:0] level;
      logic [31:0] span;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Power-on settings: threshold edges, range errors, a full trigger,
      // both suppressions, backward time and every command code.
      add_item(CMD_FRAME, 16'd0, 48'd100);
      add_item(CMD_FRAME, Q15One, 48'd110);
      add_item(CMD_FRAME, Q15One + 16'd1, 48'd120);
      add_item(CMD_FRAME, 16'hFFFF, 48'd130);
      add_item(CMD_FRAME, ThresholdReset, 48'd140);
      add_item(CMD_FRAME, ThresholdReset, 48'd150);
      add_item(CMD_FRAME, ThresholdReset, 48'd160);
      add_item(CMD_FRAME, 16'd30000, 48'd170);
      add_item(CMD_UNUSED, 16'd0, 48'd1000);
      add_item(CMD_UNUSED, 16'd0, 48'd165);
      add_item(CMD_FRAME, 16'd30000, 48'd2160);
      add_item(CMD_FRAME, ThresholdReset - 16'd1, 48'd2170);
      add_item(CMD_FRAME, 16'd30000, 48'd50);
      add_item(CMD_TRESET, 16'hFFFF, 48'd0);
      add_item(CMD_CLEAR, 16'd0, 48'hFFFF_FFFF_FFFF);
      add_item(CMD_UNUSED, 16'h5A5A, 48'hAAAA_AAAA_AAAA);
      add_item(CMD_FRAME, Q15One, 48'hFFFF_FFFF_FFFF);
      add_item(CMD_FRAME, 16'd0, 48'd0);
      wait_drained();

      // Lowest settings: every score is a hit, the first hit triggers and
      // the cooldown is off.
      write_register(CSR_THRESHOLD, {16'hFFFF, 16'd0});
      write_register(CSR_HITS, {16'hA5A5, 16'd0});
      write_register(CSR_COOLDOWN, 32'd0);
      write_register(CSR_UNUSED, $urandom);
      @(negedge clock);
      stim_ms = 48'd10;
      add_item(CMD_FRAME, 16'd0, stim_ms);
      add_random_items(40);
      wait_drained();

      // Highest settings: a threshold above one never sees a hit.
      write_register(CSR_THRESHOLD, 32'hFFFF_FFFF);
      write_register(CSR_HITS, 32'hFFFF_FFFF);
      write_register(CSR_COOLDOWN, 32'hFFFF_FFFF);
      @(negedge clock);
      add_item(CMD_FRAME, Q15One, stim_ms);
      add_random_items(30);
      wait_drained();

      // Threshold exactly one with a single-hit trigger and the longest cooldown.
      write_register(CSR_THRESHOLD, {16'd0, Q15One});
      write_register(CSR_HITS, 32'd1);
      @(negedge clock);
      add_item(CMD_FRAME, Q15One, stim_ms);
      add_random_items(30);

      for (int phase = 0; phase < RandomPhases; phase++) begin
         wait_drained();
         roll = $urandom_range(0, 19);
         if (roll < 2) level = '0;
         else if (roll < 4) level = Q15One;
         else if (roll < 5) level = 16'hFFFF;
         else level = 16'($urandom_range(12000, Q15One));
         write_register(CSR_THRESHOLD, {16'($urandom), level});
         roll = $urandom_range(0, 19);
         if (roll < 2) level = '0;
         else if (roll < 17) level = 16'($urandom_range(1, 4));
         else if (roll < 19) level = 16'($urandom_range(5, 8));
         else level = 16'hFFFF;
         write_register(CSR_HITS, {16'($urandom), level});
         roll = $urandom_range(0, 19);
         if (roll < 3) span = '0;
         else if (roll < 16) span = $urandom_range(1, 400);
         else if (roll < 19) span = $urandom_range(401, 5000);
         else span = '1;
         write_register(CSR_COOLDOWN, span);
         if ($urandom_range(0, 3) == 0) write_register(CSR_UNUSED, $urandom);
         @(negedge clock);
         // One phase runs the sender flat out against a long receiver hold
         // so that the block backs up and stalls its input.
         send_idling <= (phase == 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
         recv_idling <= (phase == 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
         if (phase == 1) holds_asked <= holds_asked + 1;
         add_random_items(PhaseItems);
      end

      wait_drained();
      repeat (4) @(posedge clock);
      if (mismatch_count == 0)
         $display("keyword_trigger_qualifier_core regression: pass");
      else
         $display("keyword_trigger_qualifier_core regression: fail");
      $finish;
   end

endmodule
